[hdl/bcdrtc_pkg.sv]
// ----------------------------------------------------------------------------
// RTC time block conversion package
// Shared types, constants and helper functions for the BCD block to epoch
// converter.
// ----------------------------------------------------------------------------
package bcdrtc_pkg;

   // Result codes.
   localparam logic [1:0] OUT_RESTORED  = 2'd0;
   localparam logic [1:0] OUT_NOT_RTC   = 2'd1;
   localparam logic [1:0] OUT_PWR_LOST  = 2'd2;
   localparam logic [1:0] OUT_NOT_SET   = 2'd3;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_DATE_POS  = 2'd0;
   localparam logic [1:0] REG_FLAG_SEC  = 2'd1;
   localparam logic [1:0] REG_FLAG_MASK = 2'd2;
   localparam logic [1:0] REG_EARLIEST  = 2'd3;

   // Register reset values.
   localparam logic [2:0]  DATE_POS_RST  = 3'd4;
   localparam logic [7:0]  FLAG_MASK_RST = 8'h80;
   localparam logic [11:0] EARLIEST_RST  = 12'd2025;

   // Field masks.
   localparam logic [7:0] SEC_MASK   = 8'h7F;
   localparam logic [7:0] MIN_MASK   = 8'h7F;
   localparam logic [7:0] HOUR_MASK  = 8'h3F;
   localparam logic [7:0] DATE_MASK  = 8'h3F;
   localparam logic [7:0] MONTH_MASK = 8'h1F;

   // Date arithmetic constants.
   localparam logic [11:0] BASE_YEAR    = 12'd2000;
   // Days from 1970-01-01 to 1999-03-01, where the day count of the shifted
   // year index counted from March 1999 starts.
   localparam logic [15:0] DAY_OFFSET   = 16'd10651;
   localparam logic [8:0]  DAYS_IN_YEAR = 9'd365;
   localparam logic [16:0] SECS_PER_DAY = 17'd86400;
   localparam logic [11:0] SECS_PER_HR  = 12'd3600;
   localparam logic [5:0]  SECS_PER_MIN = 6'd60;
   localparam logic [31:0] EPOCH_Y2000  = 32'd946684800;

   // Stage 1: decoded fields and outcome.
   typedef struct packed {
      logic [1:0] outcome;
      logic [6:0] year_idx;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } stage1_type;

   // Stage 2: day count and seconds within the day.
   typedef struct packed {
      logic [1:0]  outcome;
      logic [15:0] days;
      logic [16:0] day_secs;
   } stage2_type;

   // Stage 3: scaled day count waiting for the final sum.
   typedef struct packed {
      logic [1:0]  outcome;
      logic [31:0] day_part;
      logic [16:0] day_secs;
   } stage3_type;

   // True when both nibbles are decimal digits.
   function automatic logic bcd_digits_ok(input logic [7:0] v);
      return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9);
   endfunction

   // Binary value of a two-digit BCD byte.
   function automatic logic [6:0] bcd_to_bin(input logic [7:0] v);
      logic [7:0] tens;
      tens = {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0};
      return 7'(tens + {4'd0, v[3:0]});
   endfunction

   // Days from 1 March to the first of the given month, with January and
   // February counted at the end of the shifted year.
   function automatic logic [8:0] month_offset(input logic [3:0] month);
      logic [8:0] off;
      case (month)
         4'd3:    off = 9'd0;
         4'd4:    off = 9'd31;
         4'd5:    off = 9'd61;
         4'd6:    off = 9'd92;
         4'd7:    off = 9'd122;
         4'd8:    off = 9'd153;
         4'd9:    off = 9'd184;
         4'd10:   off = 9'd214;
         4'd11:   off = 9'd245;
         4'd12:   off = 9'd275;
         4'd1:    off = 9'd306;
         4'd2:    off = 9'd337;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

endpackage

[hdl/bcd_rtc_block_to_epoch.sv]
// A request's result strobe follows after the four pipeline stages: decode,
// day count, day scaling multiply and final sum. One request is accepted in
// every cycle. busy stays low, since the receiver cannot stall.
// Reset clears the pipeline valid bits and returns the registers to their
// reset values.
// ----------------------------------------------------------------------------
// BCD RTC block to Unix epoch converter
// Decodes and checks a BCD time block, picks the power-loss flag, sets the
// result code and, for a restored time, computes the Unix seconds.
// ----------------------------------------------------------------------------
module bcd_rtc_block_to_epoch (
   input  logic        clock,
   input  logic        reset,
   // Configuration port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata,
   // Request channel
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_sec_byte,
   input  logic [7:0]  req_min_byte,
   input  logic [7:0]  req_hour_byte,
   input  logic [7:0]  req_third_byte,
   input  logic [7:0]  req_fourth_byte,
   input  logic [7:0]  req_month_byte,
   input  logic [7:0]  req_year_byte,
   input  logic [7:0]  req_status_byte,
   input  logic        req_status_read_failed,
   // Result channel
   output logic        rsp_valid,
   output logic [1:0]  rsp_outcome,
   output logic [31:0] rsp_epoch_seconds
);

   // Configuration registers.
   logic [2:0]  date_pos_ff,  date_pos_in;
   logic        flag_sec_ff,  flag_sec_in;
   logic [7:0]  flag_mask_ff, flag_mask_in;
   logic [11:0] earliest_ff,  earliest_in;

   // Pipeline registers.
   logic                   s1_vld_ff, s2_vld_ff, s3_vld_ff;
   bcdrtc_pkg::stage1_type s1_ff, s1_in;
   bcdrtc_pkg::stage2_type s2_ff, s2_in;
   bcdrtc_pkg::stage3_type s3_ff, s3_in;
   logic                   rsp_vld_ff;
   logic [1:0]             rsp_out_ff, rsp_out_in;
   logic [31:0]            rsp_epoch_ff, rsp_epoch_in;

   logic accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Register writes.
   always_comb begin
      date_pos_in  = date_pos_ff;
      flag_sec_in  = flag_sec_ff;
      flag_mask_in = flag_mask_ff;
      earliest_in  = earliest_ff;
      if (csr_we) begin
         unique case (csr_index)
            bcdrtc_pkg::REG_DATE_POS:  date_pos_in  = csr_wdata[2:0];
            bcdrtc_pkg::REG_FLAG_SEC:  flag_sec_in  = csr_wdata[0];
            bcdrtc_pkg::REG_FLAG_MASK: flag_mask_in = csr_wdata[7:0];
            bcdrtc_pkg::REG_EARLIEST:  earliest_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         date_pos_ff  <= bcdrtc_pkg::DATE_POS_RST;
         flag_sec_ff  <= 1'b0;
         flag_mask_ff <= bcdrtc_pkg::FLAG_MASK_RST;
         earliest_ff  <= bcdrtc_pkg::EARLIEST_RST;
      end else begin
         date_pos_ff  <= date_pos_in;
         flag_sec_ff  <= flag_sec_in;
         flag_mask_ff <= flag_mask_in;
         earliest_ff  <= earliest_in;
      end
   end

   // Stage 1: mask, check and decode the fields, and settle the outcome.
   always_comb begin
      logic [7:0]  sec_m, min_m, hour_m, date_m, mon_m;
      logic [6:0]  sec_b, min_b, hour_b, date_b, mon_b, year_b;
      logic        blk_ok, lost;
      logic [11:0] year_full;
      logic        early_month;

      sec_m  = req_sec_byte & bcdrtc_pkg::SEC_MASK;
      min_m  = req_min_byte & bcdrtc_pkg::MIN_MASK;
      hour_m = req_hour_byte & bcdrtc_pkg::HOUR_MASK;
      date_m = ((date_pos_ff == 3'd3) ? req_third_byte : req_fourth_byte)
               & bcdrtc_pkg::DATE_MASK;
      mon_m  = req_month_byte & bcdrtc_pkg::MONTH_MASK;

      sec_b  = bcdrtc_pkg::bcd_to_bin(sec_m);
      min_b  = bcdrtc_pkg::bcd_to_bin(min_m);
      hour_b = bcdrtc_pkg::bcd_to_bin(hour_m);
      date_b = bcdrtc_pkg::bcd_to_bin(date_m);
      mon_b  = bcdrtc_pkg::bcd_to_bin(mon_m);
      year_b = bcdrtc_pkg::bcd_to_bin(req_year_byte);

      blk_ok = bcdrtc_pkg::bcd_digits_ok(sec_m)  && (sec_b  <= 7'd59) &&
               bcdrtc_pkg::bcd_digits_ok(min_m)  && (min_b  <= 7'd59) &&
               bcdrtc_pkg::bcd_digits_ok(hour_m) && (hour_b <= 7'd23) &&
               bcdrtc_pkg::bcd_digits_ok(date_m) && (date_b >= 7'd1) &&
               (date_b <= 7'd31) &&
               bcdrtc_pkg::bcd_digits_ok(mon_m)  && (mon_b  >= 7'd1) &&
               (mon_b <= 7'd12) &&
               bcdrtc_pkg::bcd_digits_ok(req_year_byte);

      if (flag_sec_ff)
         lost = (req_sec_byte & flag_mask_ff) != 8'd0;
      else
         lost = req_status_read_failed || ((req_status_byte & flag_mask_ff) != 8'd0);

      year_full = bcdrtc_pkg::BASE_YEAR + {5'd0, year_b};

      if (!blk_ok && !lost)
         s1_in.outcome = bcdrtc_pkg::OUT_NOT_RTC;
      else if (lost)
         s1_in.outcome = bcdrtc_pkg::OUT_PWR_LOST;
      else if (year_full < earliest_ff)
         s1_in.outcome = bcdrtc_pkg::OUT_NOT_SET;
      else
         s1_in.outcome = bcdrtc_pkg::OUT_RESTORED;

      // Year index counted from the March-based year 1999.
      early_month    = (mon_b <= 7'd2);
      s1_in.year_idx = year_b + 7'd1 - {6'd0, early_month};
      s1_in.month    = mon_b[3:0];
      s1_in.day      = date_b[4:0];
      s1_in.hour     = hour_b[4:0];
      s1_in.minute   = min_b[5:0];
      s1_in.second   = sec_b[5:0];
   end

   // Stage 2: day count since 1970 and seconds within the day.
   always_comb begin
      logic [15:0] yr_days;
      logic [4:0]  leap_days;
      logic [16:0] hr_secs;
      logic [11:0] mn_secs;

      yr_days   = 16'(s1_ff.year_idx * bcdrtc_pkg::DAYS_IN_YEAR);
      leap_days = 5'(({1'b0, s1_ff.year_idx} + 8'd3) >> 2);
      s2_in.outcome = s1_ff.outcome;
      s2_in.days    = yr_days + {11'd0, leap_days}
                      + {7'd0, bcdrtc_pkg::month_offset(s1_ff.month)}
                      + {11'd0, s1_ff.day} - 16'd1 + bcdrtc_pkg::DAY_OFFSET;
      hr_secs = 17'(s1_ff.hour * bcdrtc_pkg::SECS_PER_HR);
      mn_secs = 12'(s1_ff.minute * bcdrtc_pkg::SECS_PER_MIN);
      s2_in.day_secs = hr_secs + {5'd0, mn_secs} + {11'd0, s1_ff.second};
   end

   // Stage 3: scale the day count to seconds.
   always_comb begin
      s3_in.outcome  = s2_ff.outcome;
      s3_in.day_part = 32'(s2_ff.days * bcdrtc_pkg::SECS_PER_DAY);
      s3_in.day_secs = s2_ff.day_secs;
   end

   // Stage 4: final sum; the epoch reads as zero unless the time is restored.
   always_comb begin
      rsp_out_in = s3_ff.outcome;
      if (s3_ff.outcome == bcdrtc_pkg::OUT_RESTORED)
         rsp_epoch_in = s3_ff.day_part + {15'd0, s3_ff.day_secs};
      else
         rsp_epoch_in = 32'd0;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= accept;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         rsp_vld_ff <= s3_vld_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s1_ff        <= s1_in;
      s2_ff        <= s2_in;
      s3_ff        <= s3_in;
      rsp_out_ff   <= rsp_out_in;
      rsp_epoch_ff <= rsp_epoch_in;
   end

   assign rsp_valid         = rsp_vld_ff;
   assign rsp_outcome       = rsp_out_ff;
   assign rsp_epoch_seconds = rsp_epoch_ff;

`ifndef SYNTH
   // Every accepted request produces its result strobe once it has passed the pipeline.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("result strobe missing four cycles after a request");

   // No result appears without a matching earlier request.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##4 !rsp_valid)
      else $error("result strobe without a matching request");

   // A result that is not restored carries a zero epoch.
   a_epoch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome != bcdrtc_pkg::OUT_RESTORED)
      |-> rsp_epoch_seconds == 32'd0)
      else $error("non-zero epoch on a result that is not restored");

   // A restored time lies no earlier than the start of the year 2000.
   a_epoch_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_outcome == bcdrtc_pkg::OUT_RESTORED)
      |-> rsp_epoch_seconds >= bcdrtc_pkg::EPOCH_Y2000)
      else $error("restored epoch earlier than the year 2000");
`endif

endmodule

[verif/bcd_rtc_block_to_epoch_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTC block to epoch converter testbench
// Sends BCD time blocks through the request port under several register
// settings and sender idling patterns. Each accepted request is converted by
// a behavioural predictor, and every result strobe is checked against the
// oldest pending prediction.
// ----------------------------------------------------------------------------
module bcd_rtc_block_to_epoch_test;

   // One raw time block as read from the clock chip.
   typedef struct packed {
      logic [7:0] sec;
      logic [7:0] minute;
      logic [7:0] hour;
      logic [7:0] third;
      logic [7:0] fourth;
      logic [7:0] month;
      logic [7:0] year;
      logic [7:0] status;
      logic       status_failed;
   } rtc_block_type;

   // One predicted conversion.
   typedef struct packed {
      logic [1:0]  outcome;
      logic [31:0] epoch;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = bcdrtc_pkg::REG_DATE_POS;
   logic [11:0] csr_wdata = '0;
   logic        start = 1'b0;
   logic        busy;
   logic [7:0]  req_sec_byte = '0;
   logic [7:0]  req_min_byte = '0;
   logic [7:0]  req_hour_byte = '0;
   logic [7:0]  req_third_byte = '0;
   logic [7:0]  req_fourth_byte = '0;
   logic [7:0]  req_month_byte = '0;
   logic [7:0]  req_year_byte = '0;
   logic [7:0]  req_status_byte = '0;
   logic        req_status_read_failed = 1'b0;
   logic        rsp_valid;
   logic [1:0]  rsp_outcome;
   logic [31:0] rsp_epoch_seconds;

   // Local copy of the register settings.
   logic [2:0]  cfg_date_pos = bcdrtc_pkg::DATE_POS_RST;
   logic        cfg_flag_sec = 1'b0;
   logic [7:0]  cfg_flag_mask = bcdrtc_pkg::FLAG_MASK_RST;
   logic [11:0] cfg_earliest = bcdrtc_pkg::EARLIEST_RST;

   rtc_block_type pending_blocks[$];
   reading_type   expected_readings[$];
   rtc_block_type driven_block = '0;
   logic          req_taken = 1'b0;
   int            idle_pct = 0;
   int            failures = 0;
   int            results_checked = 0;
   int            settings_used = 1;
   int            outcome_count[4] = '{0, 0, 0, 0};

   bcd_rtc_block_to_epoch i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .start                  (start),
      .busy                   (busy),
      .req_sec_byte           (req_sec_byte),
      .req_min_byte           (req_min_byte),
      .req_hour_byte          (req_hour_byte),
      .req_third_byte         (req_third_byte),
      .req_fourth_byte        (req_fourth_byte),
      .req_month_byte         (req_month_byte),
      .req_year_byte          (req_year_byte),
      .req_status_byte        (req_status_byte),
      .req_status_read_failed (req_status_read_failed),
      .rsp_valid              (rsp_valid),
      .rsp_outcome            (rsp_outcome),
      .rsp_epoch_seconds      (rsp_epoch_seconds)
   );

   always #10 clock = ~clock;

   // Binary value of a two-digit BCD byte.
   function automatic int bcd_num(input logic [7:0] v);
      return int'(v[7:4]) * 10 + int'(v[3:0]);
   endfunction

   // True when both digits are decimal and the value lies in [lo, hi].
   function automatic logic bcd_fits(input logic [7:0] v, input int lo, input int hi);
      return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9) && (bcd_num(v) >= lo) &&
             (bcd_num(v) <= hi);
   endfunction

   // Converts a block under the current settings into outcome and Unix time.
   function automatic reading_type convert_block(input rtc_block_type b);
      logic [7:0]  s, mi, h, d, mo;
      logic        ok, lost;
      int          yr, mon, day, era, yoe, doy, doe;
      longint      days, total;
      reading_type r;
      s  = b.sec & bcdrtc_pkg::SEC_MASK;
      mi = b.minute & bcdrtc_pkg::MIN_MASK;
      h  = b.hour & bcdrtc_pkg::HOUR_MASK;
      d  = ((cfg_date_pos == 3'd3) ? b.third : b.fourth) & bcdrtc_pkg::DATE_MASK;
      mo = b.month & bcdrtc_pkg::MONTH_MASK;
      ok = bcd_fits(s, 0, 59) && bcd_fits(mi, 0, 59) && bcd_fits(h, 0, 23) &&
           bcd_fits(d, 1, 31) && bcd_fits(mo, 1, 12) && bcd_fits(b.year, 0, 99);
      // The flag comes from the raw seconds byte or from the status register.
      if (cfg_flag_sec) begin
         lost = (b.sec & cfg_flag_mask) != 8'd0;
      end else begin
         lost = b.status_failed || ((b.status & cfg_flag_mask) != 8'd0);
      end
      r.outcome = bcdrtc_pkg::OUT_RESTORED;
      r.epoch   = '0;
      if (lost) begin
         r.outcome = bcdrtc_pkg::OUT_PWR_LOST;
      end else if (!ok) begin
         r.outcome = bcdrtc_pkg::OUT_NOT_RTC;
      end else begin
         yr = 2000 + bcd_num(b.year);
         if (yr < int'(cfg_earliest)) begin
            r.outcome = bcdrtc_pkg::OUT_NOT_SET;
         end else begin
            // Day count from 1970 on a year that starts in March.
            mon = bcd_num(mo);
            day = bcd_num(d);
            if (mon <= 2) begin
               yr = yr - 1;
            end
            era   = yr / 400;
            yoe   = yr - era * 400;
            doy   = (153 * ((mon > 2) ? mon - 3 : mon + 9) + 2) / 5 + day - 1;
            doe   = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            days  = longint'(era) * 146097 + doe - 719468;
            total = days * 86400 + bcd_num(h) * 3600 + bcd_num(mi) * 60 + bcd_num(s);
            r.epoch = total[31:0];
         end
      end
      return r;
   endfunction

   // Random BCD byte with a value in [lo, hi].
   function automatic logic [7:0] random_bcd(input int lo, input int hi);
      int v;
      v = $urandom_range(hi, lo);
      return 8'(((v / 10) << 4) | (v % 10));
   endfunction

   // Mostly well-formed blocks with random content; some broken, some noise.
   function automatic rtc_block_type random_block();
      rtc_block_type b;
      logic [7:0]    date_b, wday_b;
      int            kind;
      kind = $urandom_range(99, 0);
      b = rtc_block_type'({$urandom, $urandom, $urandom});
      if (kind < 85) begin
         b.sec    = random_bcd(0, 59) | (($urandom_range(3, 0) == 0) ? 8'h80 : 8'h00);
         b.minute = random_bcd(0, 59) | {$urandom_range(1, 0) == 1, 7'd0};
         b.hour   = random_bcd(0, 23) | {2'($urandom), 6'd0};
         date_b   = random_bcd(1, 31) | {2'($urandom), 6'd0};
         wday_b   = random_bcd(1, 7) | {2'($urandom), 6'd0};
         b.month  = random_bcd(1, 12) | {3'($urandom), 5'd0};
         b.year   = random_bcd(0, 99);
         if (cfg_date_pos == 3'd3) begin
            b.third  = date_b;
            b.fourth = wday_b;
         end else begin
            b.third  = wday_b;
            b.fourth = date_b;
         end
         if ($urandom_range(4, 0) != 0) begin
            b.status = 8'($urandom) & ~cfg_flag_mask;
         end
         b.status_failed = ($urandom_range(11, 0) == 0);
         // Broken block: one field overwritten with an arbitrary byte.
         if (kind >= 70) begin
            case ($urandom_range(6, 0))
               0:       b.sec    = 8'($urandom);
               1:       b.minute = 8'($urandom);
               2:       b.hour   = 8'($urandom);
               3:       b.third  = 8'($urandom);
               4:       b.fourth = 8'($urandom);
               5:       b.month  = 8'($urandom);
               default: b.year   = 8'($urandom);
            endcase
         end
      end
      return b;
   endfunction

   // Hand-built block; the date goes to the byte the settings select.
   task automatic push_directed(input logic [7:0] s, input logic [7:0] mi,
                                input logic [7:0] h, input logic [7:0] wd,
                                input logic [7:0] d, input logic [7:0] mo,
                                input logic [7:0] y, input logic [7:0] st,
                                input logic f);
      rtc_block_type b;
      b = '{s, mi, h, wd, d, mo, y, st, f};
      if (cfg_date_pos == 3'd3) begin
         b.third  = d;
         b.fourth = wd;
      end
      pending_blocks.push_back(b);
   endtask

   // Register write on the configuration port.
   task automatic write_register(input logic [1:0] idx, input logic [11:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         bcdrtc_pkg::REG_DATE_POS:  cfg_date_pos  = value[2:0];
         bcdrtc_pkg::REG_FLAG_SEC:  cfg_flag_sec  = value[0];
         bcdrtc_pkg::REG_FLAG_MASK: cfg_flag_mask = value[7:0];
         bcdrtc_pkg::REG_EARLIEST:  cfg_earliest  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Waits until every queued request is taken and every result has come.
   task automatic settle();
      int guard;
      guard = 0;
      while (pending_blocks.size() != 0 || start) begin
         @(posedge clock);
      end
      while (expected_readings.size() != 0 && guard < 64) begin
         @(posedge clock);
         guard++;
      end
      if (expected_readings.size() != 0) begin
         $display("%0d expected results never arrived", expected_readings.size());
         failures += expected_readings.size();
         expected_readings.delete();
      end
      repeat (8) @(posedge clock);
   endtask

   // One phase: new settings, a batch of random blocks, then drain.
   task automatic run_phase(input logic [2:0] pos, input logic fsec,
                            input logic [7:0] mask, input logic [11:0] earliest,
                            input int idle, input int count);
      write_register(bcdrtc_pkg::REG_DATE_POS, {9'd0, pos});
      write_register(bcdrtc_pkg::REG_FLAG_SEC, {11'd0, fsec});
      write_register(bcdrtc_pkg::REG_FLAG_MASK, {4'd0, mask});
      write_register(bcdrtc_pkg::REG_EARLIEST, earliest);
      settings_used++;
      idle_pct = idle;
      for (int i = 0; i < count; i++) begin
         pending_blocks.push_back(random_block());
      end
      settle();
   endtask

   // Request driver: holds a request until it is taken, then moves on.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (pending_blocks.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
            driven_block = pending_blocks.pop_front();
            req_sec_byte           <= driven_block.sec;
            req_min_byte           <= driven_block.minute;
            req_hour_byte          <= driven_block.hour;
            req_third_byte         <= driven_block.third;
            req_fourth_byte        <= driven_block.fourth;
            req_month_byte         <= driven_block.month;
            req_year_byte          <= driven_block.year;
            req_status_byte        <= driven_block.status;
            req_status_read_failed <= driven_block.status_failed;
            start                  <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Result monitor: predicts on acceptance and checks each strobe.
   always @(posedge clock) begin : monitor
      reading_type want, got;
      req_taken = !reset && start && !busy;
      if (req_taken) begin
         want = convert_block(driven_block);
         expected_readings.push_back(want);
         outcome_count[want.outcome]++;
      end
      if (!reset && rsp_valid) begin
         got = '{rsp_outcome, rsp_epoch_seconds};
         if (expected_readings.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("Unexpected result: outcome %0d epoch %0d", got.outcome, got.epoch);
            end
         end else begin
            want = expected_readings.pop_front();
            results_checked++;
            if (got.outcome !== want.outcome || got.epoch !== want.epoch) begin
               failures++;
               if (failures <= 10) begin
                  $display("Mismatch: outcome %0d (expected %0d), epoch %0d (expected %0d)",
                           got.outcome, want.outcome, got.epoch, want.epoch);
               end
            end
         end
      end
   end

   // Stimulus sequence.
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed blocks under the reset settings.
      idle_pct = 0;
      push_directed(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      push_directed(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      push_directed(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
      // Year equal to the earliest allowed, one below, and the first year.
      push_directed(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h25, 8'h00, 1'b0);
      push_directed(8'h59, 8'h59, 8'h23, 8'h00, 8'h31, 8'h12, 8'h24, 8'h00, 1'b0);
      push_directed(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h00, 1'b0);
      // Last second of the range with every masked-off bit set.
      push_directed(8'hD9, 8'hD9, 8'hE3, 8'hC7, 8'hF1, 8'hF2, 8'h99, 8'h7F, 1'b0);
      // Leap day, and days past the end of February.
      push_directed(8'h45, 8'h30, 8'h12, 8'h00, 8'h29, 8'h02, 8'h28, 8'h00, 1'b0);
      push_directed(8'h00, 8'h00, 8'h00, 8'h00, 8'h31, 8'h02, 8'h25, 8'h00, 1'b0);
      push_directed(8'h00, 8'h00, 8'h00, 8'h00, 8'h31, 8'h02, 8'h28, 8'h00, 1'b0);
      push_directed(8'h07, 8'h08, 8'h09, 8'h00, 8'h01, 8'h03, 8'h25, 8'h00, 1'b0);
      // Bad digits and out-of-range fields.
      push_directed(8'h5A, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h30, 8'h00, 1'b0);
      push_directed(8'hA0, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h30, 8'h00, 1'b0);
      push_directed(8'h00, 8'h60, 8'h00, 8'h00, 8'h01, 8'h01, 8'h30, 8'h00, 1'b0);
      push_directed(8'h00, 8'h00, 8'h24, 8'h00, 8'h01, 8'h01, 8'h30, 8'h00, 1'b0);
      push_directed(8'h00, 8'h00, 8'h00, 8'h00, 8'h32, 8'h01, 8'h30, 8'h00, 1'b0);
      push_directed(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h30, 8'h00, 1'b0);
      push_directed(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h1F, 8'h30, 8'h00, 1'b0);
      push_directed(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h9A, 8'h00, 1'b0);
      push_directed(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hA0, 8'h00, 1'b0);
      // Power-loss flag: failed status read, flag bit set, invalid with flag, other bits only.
      push_directed(8'h12, 8'h34, 8'h15, 8'h03, 8'h15, 8'h06, 8'h40, 8'h00, 1'b1);
      push_directed(8'h12, 8'h34, 8'h15, 8'h03, 8'h15, 8'h06, 8'h40, 8'h80, 1'b0);
      push_directed(8'h5A, 8'h34, 8'h15, 8'h03, 8'h15, 8'h06, 8'h40, 8'h80, 1'b0);
      push_directed(8'h12, 8'h34, 8'h15, 8'h03, 8'h15, 8'h06, 8'h40, 8'h7F, 1'b0);
      settle();

      // Random phases over varied settings and idling.
      run_phase(3'd4, 1'b0, 8'h80, 12'd2025, 0, 75);
      run_phase(3'd3, 1'b0, 8'h80, 12'd2000, 56, 75);
      run_phase(3'd0, 1'b1, 8'h80, 12'd2099, 0, 75);
      run_phase(3'd7, 1'b1, 8'h01, 12'd0, 17, 75);
      run_phase(3'd4, 1'b0, 8'hFF, 12'd4095, 56, 75);
      run_phase(3'd3, 1'b1, 8'h00, 12'd2050, 0, 75);
      run_phase(3'd4, 1'b0, 8'h00, 12'd1999, 17, 75);
      run_phase(3'($urandom_range(7, 0)), 1'($urandom_range(1, 0)),
                8'($urandom_range(255, 0)), 12'($urandom_range(2110, 1990)), 56, 75);

      $display("Checked %0d results over %0d register settings.",
               results_checked, settings_used);
      $display("Outcomes: %0d restored, %0d not an RTC, %0d power lost, %0d not set.",
               outcome_count[bcdrtc_pkg::OUT_RESTORED],
               outcome_count[bcdrtc_pkg::OUT_NOT_RTC],
               outcome_count[bcdrtc_pkg::OUT_PWR_LOST],
               outcome_count[bcdrtc_pkg::OUT_NOT_SET]);
      if (failures == 0) begin
         $display("[bcd_rtc_block_to_epoch] OK");
      end else begin
         $display("[bcd_rtc_block_to_epoch] ERROR");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("Timeout with %0d requests queued and %0d results outstanding",
               pending_blocks.size(), expected_readings.size());
      $display("[bcd_rtc_block_to_epoch] ERROR");
      $finish;
   end

endmodule
